@@ design/dcu_pkg.sv @@
`default_nettype none
package dcu_pkg;

	localparam int COEFFS_PER_BLOCK      = 64;
	localparam int BLOCKS_PER_MACROBLOCK = 6;
	localparam int POS_W  = 6;
	localparam int COEF_W = 16;
	localparam int KIND_W = 3;
	localparam int LUMA_BLOCKS = 4;
	localparam logic [7:0] DC_NOT_CODED = 8'd255;

	// Transposed zigzag scan: scan index to natural position.
	localparam logic [POS_W-1:0] SCAN_ROM [COEFFS_PER_BLOCK] = '{
		6'd0,  6'd8,  6'd1,  6'd2,  6'd9,  6'd16, 6'd24, 6'd17,
		6'd10, 6'd3,  6'd4,  6'd11, 6'd18, 6'd25, 6'd32, 6'd40,
		6'd33, 6'd26, 6'd19, 6'd12, 6'd5,  6'd6,  6'd13, 6'd20,
		6'd27, 6'd34, 6'd41, 6'd48, 6'd56, 6'd49, 6'd42, 6'd35,
		6'd28, 6'd21, 6'd14, 6'd7,  6'd15, 6'd22, 6'd29, 6'd36,
		6'd43, 6'd50, 6'd57, 6'd58, 6'd51, 6'd44, 6'd37, 6'd30,
		6'd23, 6'd31, 6'd38, 6'd45, 6'd52, 6'd59, 6'd60, 6'd53,
		6'd46, 6'd39, 6'd47, 6'd54, 6'd61, 6'd62, 6'd55, 6'd63
	};

	// The escape operations take the escape field and then align what is left.
	typedef enum logic [3:0] {
		BOP_NONE, BOP_TAKE2, BOP_TAKE4, BOP_TAKE6, BOP_TAKE8,
		BOP_ALIGN4, BOP_ALIGN8, BOP_CLEAR, BOP_ESC2, BOP_ESC4
	} bop_t;

	typedef enum logic [1:0] {
		OUT_SKIP, OUT_TRUNC, OUT_COEF
	} out_sel_t;

	typedef enum logic [2:0] {
		PH_DC, PH_COUNT, PH_TWO, PH_FOUR, PH_EIGHT
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DECODE, ST_FLUSH, ST_EMIT_RD, ST_EMIT_LD, ST_END
	} state_t;

	typedef struct packed {
		logic     quant_we;
		logic     byte_load;
		logic     frame_start;
		bop_t     bop;
		logic     left_load;
		logic     left_clr;
		logic     put_ac;
		logic     place_dc;
		logic     dc_load;
		logic     clr_valid;
		logic     next_block;
		logic     emit_rd;
		logic     emit_inc;
		logic     out_load;
		out_sel_t out_sel;
	} dcu_cmd_t;

	typedef struct packed {
		logic [4:0] held;
		logic       left_zero;
		logic       esc2;
		logic       esc4;
		logic       dc_ff;
		logic       emit_last;
		logic       out_free;
	} dcu_stat_t;

endpackage
`default_nettype wire

@@ design/dcu_ram.sv @@
`default_nettype none
module dcu_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

@@ design/dcu_ctrl.sv @@
`default_nettype none
module dcu_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_req_type,
	input  wire logic              in_frame_start,
	input  wire logic              in_last,
	output logic                   in_ready,
	input  wire dcu_pkg::dcu_stat_t stat,
	output dcu_pkg::dcu_cmd_t       cmd
);

	dcu_pkg::state_t state_q, state_n;
	dcu_pkg::phase_t phase_q, phase_n;
	logic last_q, last_n;
	logic emitted_q, emitted_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dcu_pkg::ST_IDLE;
			phase_q   <= dcu_pkg::PH_DC;
			last_q    <= 1'b0;
			emitted_q <= 1'b0;
		end else begin
			state_q   <= state_n;
			phase_q   <= phase_n;
			last_q    <= last_n;
			emitted_q <= emitted_n;
		end
	end

	always_comb begin
		state_n   = state_q;
		phase_n   = phase_q;
		last_n    = last_q;
		emitted_n = emitted_q;
		in_ready  = 1'b0;
		cmd       = '0;
		cmd.bop     = dcu_pkg::BOP_NONE;
		cmd.out_sel = dcu_pkg::OUT_COEF;
		case (state_q)
			dcu_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (!in_req_type) begin
						cmd.quant_we = 1'b1;
					end else begin
						cmd.byte_load   = 1'b1;
						cmd.frame_start = in_frame_start;
						if (in_frame_start) begin
							cmd.left_clr = 1'b1;
							phase_n      = dcu_pkg::PH_DC;
						end
						last_n    = in_last;
						emitted_n = 1'b0;
						state_n   = dcu_pkg::ST_DECODE;
					end
				end
			end
			dcu_pkg::ST_DECODE: begin
				case (phase_q)
					dcu_pkg::PH_DC: begin
						if (stat.held < 5'd8) begin
							state_n = dcu_pkg::ST_END;
						end else if (stat.dc_ff) begin
							// A block that is not coded gives its single result directly, once the output is free.
							if (stat.out_free) begin
								cmd.bop        = dcu_pkg::BOP_TAKE8;
								cmd.out_load   = 1'b1;
								cmd.out_sel    = dcu_pkg::OUT_SKIP;
								cmd.next_block = 1'b1;
								emitted_n      = 1'b1;
								state_n        = dcu_pkg::ST_END;
							end
						end else begin
							cmd.bop       = dcu_pkg::BOP_TAKE8;
							cmd.dc_load   = 1'b1;
							cmd.clr_valid = 1'b1;
							phase_n       = dcu_pkg::PH_COUNT;
						end
					end
					dcu_pkg::PH_COUNT: begin
						if (stat.held < 5'd6) begin
							state_n = dcu_pkg::ST_END;
						end else begin
							cmd.bop       = dcu_pkg::BOP_TAKE6;
							cmd.left_load = 1'b1;
							phase_n       = dcu_pkg::PH_TWO;
						end
					end
					dcu_pkg::PH_TWO: begin
						if (stat.left_zero) begin
							cmd.bop = dcu_pkg::BOP_ALIGN4;
							phase_n = dcu_pkg::PH_FOUR;
						end else if (stat.held < 5'd2) begin
							state_n = dcu_pkg::ST_END;
						end else begin
							if (stat.esc2) begin
								cmd.bop = dcu_pkg::BOP_ESC2;
								phase_n = dcu_pkg::PH_FOUR;
							end else begin
								cmd.bop    = dcu_pkg::BOP_TAKE2;
								cmd.put_ac = 1'b1;
							end
						end
					end
					dcu_pkg::PH_FOUR: begin
						if (stat.left_zero) begin
							cmd.bop = dcu_pkg::BOP_ALIGN8;
							phase_n = dcu_pkg::PH_EIGHT;
						end else if (stat.held < 5'd4) begin
							state_n = dcu_pkg::ST_END;
						end else begin
							if (stat.esc4) begin
								cmd.bop = dcu_pkg::BOP_ESC4;
								phase_n = dcu_pkg::PH_EIGHT;
							end else begin
								cmd.bop    = dcu_pkg::BOP_TAKE4;
								cmd.put_ac = 1'b1;
							end
						end
					end
					dcu_pkg::PH_EIGHT: begin
						if (stat.left_zero) begin
							cmd.place_dc = 1'b1;
							phase_n      = dcu_pkg::PH_DC;
							state_n      = dcu_pkg::ST_FLUSH;
						end else if (stat.held < 5'd8) begin
							state_n = dcu_pkg::ST_END;
						end else begin
							cmd.bop    = dcu_pkg::BOP_TAKE8;
							cmd.put_ac = 1'b1;
						end
					end
					default: begin
						phase_n = dcu_pkg::PH_DC;
					end
				endcase
			end
			dcu_pkg::ST_FLUSH: begin
				state_n = dcu_pkg::ST_EMIT_RD;
			end
			dcu_pkg::ST_EMIT_RD: begin
				cmd.emit_rd = 1'b1;
				state_n     = dcu_pkg::ST_EMIT_LD;
			end
			dcu_pkg::ST_EMIT_LD: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = dcu_pkg::OUT_COEF;
					if (stat.emit_last) begin
						cmd.next_block = 1'b1;
						emitted_n      = 1'b1;
						state_n        = dcu_pkg::ST_END;
					end else begin
						cmd.emit_inc = 1'b1;
						state_n      = dcu_pkg::ST_EMIT_RD;
					end
				end
			end
			dcu_pkg::ST_END: begin
				if (!last_q) begin
					state_n = dcu_pkg::ST_IDLE;
				end else if (!emitted_q &&
						(phase_q != dcu_pkg::PH_DC || stat.held != 5'd0)) begin
					if (stat.out_free) begin
						cmd.out_load = 1'b1;
						cmd.out_sel  = dcu_pkg::OUT_TRUNC;
						cmd.bop      = dcu_pkg::BOP_CLEAR;
						cmd.left_clr = 1'b1;
						phase_n      = dcu_pkg::PH_DC;
						state_n      = dcu_pkg::ST_IDLE;
					end
				end else begin
					cmd.bop      = dcu_pkg::BOP_CLEAR;
					cmd.left_clr = 1'b1;
					phase_n      = dcu_pkg::PH_DC;
					state_n      = dcu_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = dcu_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ design/dcu_datapath.sv @@
`default_nettype none
module dcu_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dcu_pkg::dcu_cmd_t  cmd,
	output dcu_pkg::dcu_stat_t      stat,
	input  wire logic [7:0]         stream_byte,
	input  wire logic               quant_table,
	input  wire logic [5:0]         quant_index,
	input  wire logic [15:0]        quant_value,
	input  wire logic               out_ready,
	output logic                    out_valid,
	output logic [15:0]             coef_value,
	output logic [5:0]              coef_position,
	output logic                    block_coded,
	output logic [2:0]              block_kind,
	output logic                    status,
	output logic                    last
);

	logic [15:0] hold_q, hold_n, hold_base;
	logic [4:0]  held_q, held_n, held_base, win_sh;
	logic [4:0]  held_m2, held_m4;
	logic [15:0] win;
	logic [5:0]  left_q;
	logic [7:0]  dc_q;
	logic [2:0]  kind_q;
	logic [63:0] valid_q;
	logic [5:0]  emit_q;
	logic        out_valid_q;
	logic        out_free;

	logic [15:0] field_val;
	logic [5:0]  rd_pos;
	logic [15:0] val_s1;
	logic [5:0]  pos_s1;
	logic        wr_s1;
	logic [15:0] lq_rd, cq_rd, coef_rd, q_sel;
	logic [31:0] prod;

	// The held bits are top-aligned so that each field is a fixed slice.
	assign win_sh = 5'd16 - held_q;
	assign win    = hold_q << win_sh;

	assign held_m2 = held_q - 5'd2;
	assign held_m4 = held_q - 5'd4;

	always_comb begin
		held_n = held_q;
		case (cmd.bop)
			dcu_pkg::BOP_TAKE2:  held_n = held_q - 5'd2;
			dcu_pkg::BOP_TAKE4:  held_n = held_q - 5'd4;
			dcu_pkg::BOP_TAKE6:  held_n = held_q - 5'd6;
			dcu_pkg::BOP_TAKE8:  held_n = held_q - 5'd8;
			dcu_pkg::BOP_ALIGN4: held_n = {held_q[4:2], 2'b00};
			dcu_pkg::BOP_ALIGN8: held_n = {held_q[4:3], 3'b000};
			dcu_pkg::BOP_ESC2:   held_n = {held_m2[4:2], 2'b00};
			dcu_pkg::BOP_ESC4:   held_n = {held_m4[4:3], 3'b000};
			dcu_pkg::BOP_CLEAR:  held_n = 5'd0;
			default:             held_n = held_q;
		endcase
		hold_n = hold_q & ~(16'hFFFF << held_n);
		if (cmd.frame_start || held_q > 5'd8) begin
			hold_base = 16'd0;
			held_base = 5'd0;
		end else begin
			hold_base = hold_q;
			held_base = held_q;
		end
		if (cmd.byte_load) begin
			hold_n = {hold_base[7:0], stream_byte};
			held_n = held_base + 5'd8;
		end
	end

	always_comb begin
		case (cmd.bop)
			dcu_pkg::BOP_TAKE2: field_val = {{14{win[15]}}, win[15:14]};
			dcu_pkg::BOP_TAKE4: field_val = {{12{win[15]}}, win[15:12]};
			default:            field_val = {{8{win[15]}}, win[15:8]};
		endcase
		if (cmd.place_dc) begin
			field_val = {8'd0, dc_q};
		end
	end

	assign rd_pos = cmd.place_dc ? dcu_pkg::SCAN_ROM[0] : dcu_pkg::SCAN_ROM[left_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q      <= '0;
			held_q      <= '0;
			left_q      <= '0;
			dc_q        <= '0;
			kind_q      <= '0;
			valid_q     <= '0;
			emit_q      <= '0;
			wr_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			hold_q <= hold_n;
			held_q <= held_n;
			if (cmd.left_clr) begin
				left_q <= '0;
			end else if (cmd.left_load) begin
				left_q <= win[15:10];
			end else if (cmd.put_ac) begin
				left_q <= left_q - 6'd1;
			end
			if (cmd.dc_load) begin
				dc_q <= win[15:8];
			end
			if (cmd.byte_load && cmd.frame_start) begin
				kind_q <= '0;
			end else if (cmd.next_block) begin
				kind_q <= (kind_q == 3'(dcu_pkg::BLOCKS_PER_MACROBLOCK - 1)) ?
					3'd0 : kind_q + 3'd1;
			end
			if (cmd.clr_valid) begin
				valid_q <= '0;
			end else if (wr_s1) begin
				valid_q[pos_s1] <= 1'b1;
			end
			if (cmd.place_dc) begin
				emit_q <= '0;
			end else if (cmd.emit_inc) begin
				emit_q <= emit_q + 6'd1;
			end
			wr_s1 <= cmd.put_ac || cmd.place_dc;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		val_s1 <= field_val;
		pos_s1 <= rd_pos;
	end

	dcu_ram #(.WIDTH(16), .DEPTH(64)) u_luma_q (
		.clk(clk), .we(cmd.quant_we && !quant_table), .wr_addr(quant_index),
		.wr_data(quant_value), .rd_en(1'b1), .rd_addr(rd_pos), .rd_data(lq_rd)
	);

	dcu_ram #(.WIDTH(16), .DEPTH(64)) u_chroma_q (
		.clk(clk), .we(cmd.quant_we && quant_table), .wr_addr(quant_index),
		.wr_data(quant_value), .rd_en(1'b1), .rd_addr(rd_pos), .rd_data(cq_rd)
	);

	assign q_sel = (kind_q < 3'(dcu_pkg::LUMA_BLOCKS)) ? lq_rd : cq_rd;
	assign prod  = val_s1 * q_sel;

	dcu_ram #(.WIDTH(16), .DEPTH(64)) u_coef (
		.clk(clk), .we(wr_s1), .wr_addr(pos_s1), .wr_data(prod[15:0]),
		.rd_en(cmd.emit_rd), .rd_addr(emit_q), .rd_data(coef_rd)
	);

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			block_kind <= kind_q;
			case (cmd.out_sel)
				dcu_pkg::OUT_COEF: begin
					coef_value    <= valid_q[emit_q] ? coef_rd : 16'd0;
					coef_position <= emit_q;
					block_coded   <= 1'b1;
					status        <= 1'b0;
					last          <= (emit_q == 6'(dcu_pkg::COEFFS_PER_BLOCK - 1));
				end
				dcu_pkg::OUT_TRUNC: begin
					coef_value    <= 16'd0;
					coef_position <= 6'd0;
					block_coded   <= 1'b1;
					status        <= 1'b1;
					last          <= 1'b1;
				end
				default: begin
					coef_value    <= 16'd0;
					coef_position <= 6'd0;
					block_coded   <= 1'b0;
					status        <= 1'b0;
					last          <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

	assign stat.held      = held_q;
	assign stat.left_zero = (left_q == 6'd0);
	assign stat.esc2      = (win[15:14] == 2'b10);
	assign stat.esc4      = (win[15:12] == 4'b1000);
	assign stat.dc_ff     = (win[15:8] == dcu_pkg::DC_NOT_CODED);
	assign stat.emit_last = (emit_q == 6'(dcu_pkg::COEFFS_PER_BLOCK - 1));
	assign stat.out_free  = out_free;

endmodule
`default_nettype wire

@@ design/dct_block_coefficient_unpacker_core.sv @@
`default_nettype none
// Unpacks 8x8 coefficient blocks from an MSB-first byte stream and dequantizes
// them. Each input transfer is either a quantizer word load (no result) or one
// stream byte. A byte is decoded one field or alignment step per cycle unless a
// stalled output holds a step: after its transfer come its steps, one step that
// finds too few bits left (unless a block completes) and a closing state. A
// finished coded block then passes through a flush state and gives its 64
// results, each read from the coefficient memory in a read state and loaded to
// the output in a load state, and a block that is not coded gives one result;
// a stalled output holds the input off. The quantizer tables must be loaded
// before any block uses them; an unloaded entry gives an undefined coefficient.
module dct_block_coefficient_unpacker_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // stream_byte, quant_index, quant_value, zero pad
	input  wire logic [2:0]  s_tuser,  // req_type, frame_start, quant_table
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,  // coef_value, coef_position, zero pad
	output logic [4:0]       m_tuser,  // block_coded, block_kind, status
	output logic             m_tlast
);

	dcu_pkg::dcu_cmd_t  cmd;
	dcu_pkg::dcu_stat_t stat;
	logic [15:0] coef_value;
	logic [5:0]  coef_position;
	logic        block_coded;
	logic [2:0]  block_kind;
	logic        status;

	dcu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_req_type(s_tuser[0]), .in_frame_start(s_tuser[1]),
		.in_last(s_tlast), .in_ready(s_tready), .stat(stat), .cmd(cmd)
	);

	dcu_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.stream_byte(s_tdata[7:0]), .quant_table(s_tuser[2]),
		.quant_index(s_tdata[13:8]), .quant_value(s_tdata[29:14]),
		.out_ready(m_tready), .out_valid(m_tvalid),
		.coef_value(coef_value), .coef_position(coef_position),
		.block_coded(block_coded), .block_kind(block_kind),
		.status(status), .last(m_tlast)
	);

	assign m_tdata = {2'b00, coef_position, coef_value};
	assign m_tuser = {status, block_kind, block_coded};

endmodule
`default_nettype wire

@@ dv/dct_block_coefficient_unpacker_core_tb.sv @@
`default_nettype none
module dct_block_coefficient_unpacker_core_tb;

	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [15:0] value;
		logic [5:0]  pos;
		logic        coded;
		logic [2:0]  kind;
		logic        status;
		logic        last;
	} coef_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic [4:0]  m_tuser;
	logic        m_tlast;

	dct_block_coefficient_unpacker_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	// Decoder state as the block should hold it.
	logic [15:0] luma_q [dcu_pkg::COEFFS_PER_BLOCK];
	logic [15:0] chroma_q [dcu_pkg::COEFFS_PER_BLOCK];
	logic [15:0] coef_mem [dcu_pkg::COEFFS_PER_BLOCK];
	int unsigned hold_bits;
	int          held;
	dcu_pkg::phase_t phase;
	int          left;
	int          dc_val;
	int          kind;

	coef_t coef_expect [$];
	bit    bitq [$];
	int    errors;
	int    sent_items;
	int    idle_cycles;
	bit    steady;
	bit    hold_req;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic int take_bits(int n);
		int v;
		v = (hold_bits >> (held - n)) & ((1 << n) - 1);
		held -= n;
		hold_bits &= (1 << held) - 1;
		return v;
	endfunction

	function automatic void align_to(int a);
		void'(take_bits(held % a));
	endfunction

	function automatic int sign_ext(int v, int n);
		return (v >= (1 << (n - 1))) ? v - (1 << n) : v;
	endfunction

	function automatic void store_coef(int c, int scan_idx);
		int          pos;
		int unsigned q;
		pos = dcu_pkg::SCAN_ROM[scan_idx & 63];
		q = (kind < dcu_pkg::LUMA_BLOCKS) ? luma_q[pos] : chroma_q[pos];
		coef_mem[pos] = 16'(c * q);
	endfunction

	function automatic void put_ac(int c);
		store_coef(c, left);
		left = (left - 1) & 63;
	endfunction

	function automatic void push_result(logic [15:0] v, int pos, bit coded, bit st, bit lst);
		coef_t r;
		r.value = v;
		r.pos = 6'(pos);
		r.coded = coded;
		r.kind = 3'(kind);
		r.status = st;
		r.last = lst;
		coef_expect.push_back(r);
	endfunction

	// Works out the results caused by one accepted byte.
	function automatic void decode_byte(logic [7:0] b, bit lst, bit fs);
		int n;
		bit done;
		int c;
		n = 0;
		done = 0;
		if (fs) begin
			hold_bits = 0;
			held = 0;
			phase = dcu_pkg::PH_DC;
			left = 0;
			kind = 0;
		end
		if (held > 8) begin
			hold_bits = 0;
			held = 0;
		end
		hold_bits = ((hold_bits << 8) | b) & 16'hFFFF;
		held += 8;
		while (!done) begin
			if (phase == dcu_pkg::PH_COUNT) begin
				if (held < 6) break;
				left = take_bits(6);
				phase = dcu_pkg::PH_TWO;
			end else if (phase == dcu_pkg::PH_TWO) begin
				if (left == 0) begin
					align_to(4);
					phase = dcu_pkg::PH_FOUR;
				end else if (held < 2) begin
					break;
				end else begin
					c = sign_ext(take_bits(2), 2);
					if (c == -2) begin
						align_to(4);
						phase = dcu_pkg::PH_FOUR;
					end else begin
						put_ac(c);
					end
				end
			end else if (phase == dcu_pkg::PH_FOUR) begin
				if (left == 0) begin
					align_to(8);
					phase = dcu_pkg::PH_EIGHT;
				end else if (held < 4) begin
					break;
				end else begin
					c = sign_ext(take_bits(4), 4);
					if (c == -8) begin
						align_to(8);
						phase = dcu_pkg::PH_EIGHT;
					end else begin
						put_ac(c);
					end
				end
			end else if (phase == dcu_pkg::PH_EIGHT) begin
				if (left == 0) begin
					store_coef(dc_val, 0);
					for (int p = 0; p < dcu_pkg::COEFFS_PER_BLOCK; p++)
						push_result(coef_mem[p], p, 1'b1, 1'b0,
							p == dcu_pkg::COEFFS_PER_BLOCK - 1);
					n = dcu_pkg::COEFFS_PER_BLOCK;
					kind = (kind + 1) % dcu_pkg::BLOCKS_PER_MACROBLOCK;
					phase = dcu_pkg::PH_DC;
					done = 1;
				end else if (held < 8) begin
					break;
				end else begin
					put_ac(sign_ext(take_bits(8), 8));
				end
			end else begin
				if (held < 8) break;
				dc_val = take_bits(8);
				if (dc_val == int'(dcu_pkg::DC_NOT_CODED)) begin
					push_result(16'd0, 0, 1'b0, 1'b0, 1'b1);
					n = 1;
					kind = (kind + 1) % dcu_pkg::BLOCKS_PER_MACROBLOCK;
					phase = dcu_pkg::PH_DC;
					done = 1;
				end else begin
					foreach (coef_mem[i]) coef_mem[i] = '0;
					phase = dcu_pkg::PH_COUNT;
				end
			end
		end
		if (lst) begin
			// A buffer that ends inside a block reports one truncation result.
			if (n == 0 && (phase != dcu_pkg::PH_DC || held > 0))
				push_result(16'd0, 0, 1'b1, 1'b1, 1'b1);
			hold_bits = 0;
			held = 0;
			phase = dcu_pkg::PH_DC;
			left = 0;
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_item(input logic [2:0] user, input logic [31:0] data, input logic lst);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= user;
		s_tdata <= data;
		s_tlast <= lst;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent_items++;
		if (user[0]) begin
			decode_byte(data[7:0], lst, user[1]);
		end else if (user[2]) begin
			chroma_q[data[13:8]] = data[29:14];
		end else begin
			luma_q[data[13:8]] = data[29:14];
		end
	endtask

	task automatic load_quant(input bit chroma, input int idx, input logic [15:0] v);
		send_item({chroma, 1'($urandom), 1'b0},
			{2'b00, v, 6'(idx), 8'($urandom)}, 1'($urandom));
	endtask

	task automatic push_field(input int v, input int n);
		for (int i = n - 1; i >= 0; i--) bitq.push_back(v[i]);
	endtask

	task automatic pad_to(input int a);
		while (bitq.size() % a != 0) bitq.push_back(1'b0);
	endtask

	// Appends one block in the stream format. Style: 0 random split of the
	// AC values, 1 all in two-bit fields, 2 straight to eight-bit fields.
	task automatic add_block(input logic [7:0] dc, input int cnt, input int style);
		int rest;
		int n2;
		int n4;
		push_field(dc, 8);
		if (dc == dcu_pkg::DC_NOT_CODED) return;
		push_field(cnt, 6);
		rest = cnt;
		n2 = (style == 1) ? rest : (style == 2) ? 0 : $urandom_range(0, rest);
		for (int i = 0; i < n2; i++) push_field(sign_ext($urandom_range(0, 2) + 3, 2), 2);
		rest -= n2;
		if (rest > 0) push_field(2, 2);
		pad_to(4);
		n4 = (style == 2) ? 0 : $urandom_range(0, rest);
		for (int i = 0; i < n4; i++) push_field($urandom_range(0, 14) + 9, 4);
		rest -= n4;
		if (rest > 0) push_field(8, 4);
		pad_to(8);
		for (int i = 0; i < rest; i++) push_field($urandom_range(0, 255), 8);
	endtask

	// Sends the queued bits as bytes. Cut: 0 whole buffer with the end
	// marked, 1 ends early with the end marked, 2 stops early without it.
	task automatic send_stream(input bit fs, input int cut);
		int total;
		int k;
		logic [7:0] b;
		total = bitq.size() / 8;
		k = (cut != 0 && total > 1) ? $urandom_range(1, total - 1) : total;
		for (int i = 0; i < k; i++) begin
			for (int j = 0; j < 8; j++) b[7 - j] = bitq[i * 8 + j];
			send_item({1'($urandom), fs && i == 0, 1'b1},
				{2'b00, 16'($urandom), 6'($urandom), b}, (i == k - 1) && cut != 2);
		end
		bitq.delete();
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		wait (coef_expect.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic test_quant_tables();
		for (int i = 0; i < dcu_pkg::COEFFS_PER_BLOCK; i++) begin
			load_quant(1'b0, i, (i == 0) ? 16'hFFFF : 16'($urandom_range(1, 40)));
			load_quant(1'b1, i, (i == 63) ? 16'h0000 : 16'($urandom));
		end
	endtask

	task automatic test_directed_blocks();
		add_block(dcu_pkg::DC_NOT_CODED, 0, 0);
		add_block(8'd0, 0, 0);
		add_block(8'd254, 63, 1);
		add_block(8'd128, 3, 2);
		add_block(8'd17, 10, 0);
		send_stream(1'b1, 0);
		// Frame start drops a half-decoded block.
		add_block(8'd5, 20, 0);
		send_stream(1'b0, 2);
		add_block(8'd9, 2, 0);
		send_stream(1'b1, 0);
		// Buffer ending inside a block.
		add_block(8'd33, 12, 0);
		send_stream(1'b0, 1);
		wait_drain();
	endtask

	task automatic test_backpressure();
		hold_req = 1'b1;
		steady = 1'b1;
		for (int i = 0; i < 3; i++) add_block(8'($urandom_range(0, 254)), 6, 0);
		send_stream(1'b0, 0);
		steady = 1'b0;
		wait_drain();
	endtask

	task automatic test_random_stream();
		int nblk;
		do begin
			if ($urandom_range(0, 9) == 0)
				load_quant(1'($urandom), $urandom_range(0, 63), 16'($urandom));
			if ($urandom_range(0, 9) == 0) begin
				send_item({1'($urandom), 1'($urandom), 1'b1},
					{2'b00, 16'($urandom), 6'($urandom), 8'($urandom)}, 1'($urandom));
			end else begin
				nblk = $urandom_range(1, 4);
				for (int i = 0; i < nblk; i++)
					add_block(($urandom_range(0, 7) == 0) ? dcu_pkg::DC_NOT_CODED :
						8'($urandom_range(0, 254)),
						($urandom_range(0, 19) == 0) ? 63 : $urandom_range(0, 15), 0);
				send_stream($urandom_range(0, 3) == 0, ($urandom_range(0, 9) == 0) ? 1 : 0);
			end
			steady = ($urandom_range(0, 5) == 0);
		end while (sent_items < 170);
		steady = 1'b0;
	endtask

	// Receiver: random stalls, plus one long hold-off counted here.
	initial begin : receiver
		int stall_left;
		int hold_cnt;
		stall_left = 0;
		hold_cnt = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_cnt = 400;
				hold_req = 1'b0;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_tready <= 1'b0;
			end else if (steady) begin
				m_tready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin : result_check
		coef_t got;
		coef_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[15:0], m_tdata[21:16], m_tuser[0], m_tuser[3:1], m_tuser[4], m_tlast};
			if (coef_expect.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
			end else begin
				want = coef_expect.pop_front();
				if (got !== want) begin
					$display("%0t: mismatch expected %p actual %p", $time, want, got);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("dct_block_coefficient_unpacker_core test failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		s_tlast = 1'b0;
		errors = 0;
		sent_items = 0;
		idle_cycles = 0;
		steady = 1'b0;
		hold_req = 1'b0;
		hold_bits = 0;
		held = 0;
		phase = dcu_pkg::PH_DC;
		left = 0;
		dc_val = 0;
		kind = 0;
		foreach (coef_mem[i]) coef_mem[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_quant_tables();
		test_directed_blocks();
		test_backpressure();
		test_random_stream();
		s_tvalid <= 1'b0;
		wait (coef_expect.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0 && coef_expect.size() == 0)
			$display("dct_block_coefficient_unpacker_core test passed");
		else
			$display("dct_block_coefficient_unpacker_core test failed");
		$finish;
	end

endmodule
`default_nettype wire
